// ===== rtl/ab_rvs_pkg.sv =====
// Package for the A/B record validate and select block.
// Holds the item types, register and outcome codes and the CRC-32 byte step.
// No dependencies.
`default_nettype none

package ab_rvs_pkg;

  // Default for the longest record the byte counter tracks.
  localparam int MAX_RECORD_BYTES_DEF = 4096;

  // Header layout in bytes.
  localparam int HDR_BYTES     = 16;
  localparam int HDR_CRC_BYTES = 12;
  localparam int CFG_PAYLOAD_W = 12;

  // Reflected zlib CRC-32 polynomial and its start value.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Reset value of the payload size register.
  localparam logic [CFG_PAYLOAD_W-1:0] PAYLOAD_BYTES_RST = 12'd64;

  // Input actions.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_PICK = 1'b1;

  // Configuration register indexes.
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_MAGIC   = 2'd0;
  localparam cfg_index_t CFG_VERSION = 2'd1;
  localparam cfg_index_t CFG_PAYLOAD = 2'd2;

  // Pick outcomes.
  typedef logic [1:0] outcome_t;
  localparam outcome_t OUT_FRESH  = 2'd0;
  localparam outcome_t OUT_FROM_A = 2'd1;
  localparam outcome_t OUT_FROM_B = 2'd2;

  // One input item.
  typedef struct packed {
    logic       action;
    logic       slot;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    outcome_t    outcome;
    logic [31:0] active_generation;
    logic        next_write_to_a;
    logic        a_valid;
    logic        b_valid;
  } out_item_t;

  // Verdict handed from the collector to the slot store at a record's end.
  typedef struct packed {
    logic        wr;
    logic        slot;
    logic        ok;
    logic [31:0] generation;
  } verdict_t;

  // One byte step of the reflected CRC-32.
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ab_rvs_collect.sv =====
// Byte collector: counts record bytes, captures the header, runs the CRC-32
// and forms the verdict on the last byte. Depends on ab_rvs_pkg.
`default_nettype none

module ab_rvs_collect #(
  parameter int MAX_RECORD_BYTES = ab_rvs_pkg::MAX_RECORD_BYTES_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      byte_en,
  input  wire ab_rvs_pkg::in_item_t                item,
  input  wire [31:0]                               expected_magic,
  input  wire [15:0]                               expected_version,
  input  wire [ab_rvs_pkg::CFG_PAYLOAD_W-1:0]      payload_bytes,
  output ab_rvs_pkg::verdict_t                     verdict
);

  // The counter saturates at MAX_RECORD_BYTES + 1.
  localparam int OFF_W = $clog2(MAX_RECORD_BYTES + 2);
  localparam int PEND_W = ab_rvs_pkg::CFG_PAYLOAD_W + 1;
  localparam int CMP_W = (OFF_W > PEND_W) ? OFF_W : PEND_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_RECORD_BYTES);
  localparam logic [CMP_W-1:0] HDR_C = CMP_W'(ab_rvs_pkg::HDR_BYTES);
  localparam logic [CMP_W-1:0] HCRC_C = CMP_W'(ab_rvs_pkg::HDR_CRC_BYTES);
  localparam logic [CMP_W-1:0] EIGHT_C = CMP_W'(8);

  logic [OFF_W-1:0] offset_r, offset_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [63:0]      hdr_r, hdr_nxt;
  logic [31:0]      gen_r, gen_nxt;
  logic [31:0]      scrc_r, scrc_nxt;

  logic [CMP_W-1:0] idx;
  logic [CMP_W-1:0] cnt;
  logic [CMP_W-1:0] pend;
  logic [OFF_W-1:0] offset_inc;
  logic [31:0]      crc_upd;
  logic [63:0]      hdr_upd;
  logic [31:0]      gen_upd;
  logic [31:0]      scrc_upd;
  logic             in_crc;
  logic             ok;

  assign idx  = CMP_W'(offset_r);
  assign pend = CMP_W'({1'b0, payload_bytes}) + HDR_C;

  // Header capture: each header byte lands in its own lane.
  always_comb begin
    hdr_upd  = hdr_r;
    gen_upd  = gen_r;
    scrc_upd = scrc_r;
    for (int i = 0; i < 8; i++) begin
      if (idx < EIGHT_C && offset_r[2:0] == 3'(i)) begin
        hdr_upd[8*i +: 8] = item.data;
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (idx >= EIGHT_C && idx < HCRC_C && offset_r[1:0] == 2'(i)) begin
        gen_upd[8*i +: 8] = item.data;
      end
      if (idx >= HCRC_C && idx < HDR_C && offset_r[1:0] == 2'(i)) begin
        scrc_upd[8*i +: 8] = item.data;
      end
    end
  end

  // CRC covers header bytes before the stored CRC and the payload.
  assign in_crc  = (idx < HCRC_C) || (idx >= HDR_C && idx < pend);
  assign crc_upd = in_crc ? ab_rvs_pkg::crc32_byte(crc_r, item.data) : crc_r;

  // Saturating byte count.
  assign offset_inc = (idx <= MAX_C) ? offset_r + OFF_W'(1) : offset_r;
  assign cnt = CMP_W'(offset_inc);

  // Verdict uses the header as it stands after this byte.
  assign ok = (cnt >= pend) && (cnt <= MAX_C) &&
              (hdr_upd[31:0] == expected_magic) &&
              (hdr_upd[47:32] == expected_version) &&
              (hdr_upd[63:48] == {4'd0, payload_bytes}) &&
              ((crc_upd ^ ab_rvs_pkg::CRC_INIT) == scrc_upd);

  assign verdict.wr         = byte_en && item.last;
  assign verdict.slot       = item.slot;
  assign verdict.ok         = ok;
  assign verdict.generation = gen_upd;

  // Next collector state; the last byte returns it to its cleared values.
  always_comb begin
    offset_nxt = offset_r;
    crc_nxt    = crc_r;
    hdr_nxt    = hdr_r;
    gen_nxt    = gen_r;
    scrc_nxt   = scrc_r;
    if (byte_en) begin
      if (item.last) begin
        offset_nxt = '0;
        crc_nxt    = ab_rvs_pkg::CRC_INIT;
        hdr_nxt    = '0;
        gen_nxt    = '0;
        scrc_nxt   = '0;
      end else begin
        offset_nxt = offset_inc;
        crc_nxt    = crc_upd;
        hdr_nxt    = hdr_upd;
        gen_nxt    = gen_upd;
        scrc_nxt   = scrc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      crc_r    <= ab_rvs_pkg::CRC_INIT;
      hdr_r    <= '0;
      gen_r    <= '0;
      scrc_r   <= '0;
    end else begin
      offset_r <= offset_nxt;
      crc_r    <= crc_nxt;
      hdr_r    <= hdr_nxt;
      gen_r    <= gen_nxt;
      scrc_r   <= scrc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ab_rvs_select.sv =====
// Slot store and pick logic with the result register.
// Keeps the verdict and generation of each slot. Depends on ab_rvs_pkg.
`default_nettype none

module ab_rvs_select (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire ab_rvs_pkg::verdict_t  verdict,
  input  wire                        pick_req,
  output logic                       pick_stall,
  output logic                       out_valid,
  input  wire                        out_stall,
  output ab_rvs_pkg::out_item_t      out_item
);

  logic        a_ok_r, a_ok_nxt;
  logic        b_ok_r, b_ok_nxt;
  logic [31:0] a_gen_r, a_gen_nxt;
  logic [31:0] b_gen_r, b_gen_nxt;
  logic        out_valid_r, out_valid_nxt;
  ab_rvs_pkg::out_item_t out_item_r, pick_res;
  logic        pick_go;

  // A pending result that is stalled holds off the next pick item.
  assign pick_stall = out_valid_r && out_stall;
  assign pick_go    = pick_req && !pick_stall;

  // Store the verdict of a finished record.
  always_comb begin
    a_ok_nxt  = a_ok_r;
    b_ok_nxt  = b_ok_r;
    a_gen_nxt = a_gen_r;
    b_gen_nxt = b_gen_r;
    if (verdict.wr) begin
      if (verdict.slot) begin
        b_ok_nxt  = verdict.ok;
        b_gen_nxt = verdict.generation;
      end else begin
        a_ok_nxt  = verdict.ok;
        a_gen_nxt = verdict.generation;
      end
    end
  end

  // Higher generation wins; a tie goes to slot A.
  always_comb begin
    pick_res.a_valid = a_ok_r;
    pick_res.b_valid = b_ok_r;
    if (a_ok_r && (!b_ok_r || a_gen_r >= b_gen_r)) begin
      pick_res.outcome           = ab_rvs_pkg::OUT_FROM_A;
      pick_res.active_generation = a_gen_r;
      pick_res.next_write_to_a   = 1'b0;
    end else if (b_ok_r) begin
      pick_res.outcome           = ab_rvs_pkg::OUT_FROM_B;
      pick_res.active_generation = b_gen_r;
      pick_res.next_write_to_a   = 1'b1;
    end else begin
      pick_res.outcome           = ab_rvs_pkg::OUT_FRESH;
      pick_res.active_generation = '0;
      pick_res.next_write_to_a   = 1'b1;
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pick_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ok_r      <= 1'b0;
      b_ok_r      <= 1'b0;
      a_gen_r     <= '0;
      b_gen_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_ok_r      <= a_ok_nxt;
      b_ok_r      <= b_ok_nxt;
      a_gen_r     <= a_gen_nxt;
      b_gen_r     <= b_gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pick_go) begin
      out_item_r <= pick_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/ab_record_validate_select.sv =====
// Top level of the A/B record validate and select block.
// Holds the input register and configuration registers; instantiates
// ab_rvs_collect and ab_rvs_select. Depends on ab_rvs_pkg.
//
//   Port group  Direction  Handshake          Carries
//   in_*        input      in_valid/in_stall  ab_rvs_pkg::in_item_t
//   out_*       output     out_valid/out_stall ab_rvs_pkg::out_item_t
//   cfg_*       input      cfg_valid/cfg_ready register index, 32-bit data
//
// One item is accepted per cycle while in_stall is low. A byte item passes
// the input register to the collector; a pick item passes it to the result
// register, where out_valid rises and the result can be taken. rst_n is
// synchronous; reset clears the collector, both slot verdicts and the valid
// flags and resets the cfg registers. While a result waits under out_stall,
// a pick item in the input register waits too, and only then does in_stall rise.
`default_nettype none

module ab_record_validate_select #(
  parameter int MAX_RECORD_BYTES = ab_rvs_pkg::MAX_RECORD_BYTES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire ab_rvs_pkg::in_item_t    in_item,
  output logic                         out_valid,
  input  wire                          out_stall,
  output ab_rvs_pkg::out_item_t        out_item,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire ab_rvs_pkg::cfg_index_t  cfg_index,
  input  wire [31:0]                   cfg_wdata
);

  logic                 s1_valid_r, s1_valid_nxt;
  ab_rvs_pkg::in_item_t s1_item_r;
  logic [31:0]          magic_r, magic_nxt;
  logic [15:0]          version_r, version_nxt;
  logic [ab_rvs_pkg::CFG_PAYLOAD_W-1:0] payload_r, payload_nxt;

  ab_rvs_pkg::verdict_t verdict;
  logic                 byte_en;
  logic                 pick_req;
  logic                 pick_stall;
  logic                 cfg_wr;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    payload_nxt = payload_r;
    if (cfg_wr) begin
      case (cfg_index)
        ab_rvs_pkg::CFG_MAGIC:   magic_nxt   = cfg_wdata;
        ab_rvs_pkg::CFG_VERSION: version_nxt = cfg_wdata[15:0];
        ab_rvs_pkg::CFG_PAYLOAD: payload_nxt = cfg_wdata[ab_rvs_pkg::CFG_PAYLOAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: a byte item always completes; a pick item waits on the result.
  assign byte_en  = s1_valid_r && (s1_item_r.action == ab_rvs_pkg::ACT_BYTE);
  assign pick_req = s1_valid_r && (s1_item_r.action == ab_rvs_pkg::ACT_PICK);
  assign in_stall = pick_req && pick_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      magic_r    <= '0;
      version_r  <= '0;
      payload_r  <= ab_rvs_pkg::PAYLOAD_BYTES_RST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      magic_r    <= magic_nxt;
      version_r  <= version_nxt;
      payload_r  <= payload_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  // Byte collector and verdict.
  ab_rvs_collect #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_collect (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_en          (byte_en),
    .item             (s1_item_r),
    .expected_magic   (magic_r),
    .expected_version (version_r),
    .payload_bytes    (payload_r),
    .verdict          (verdict)
  );

  // Slot store, pick and result register.
  ab_rvs_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .verdict    (verdict),
    .pick_req   (pick_req),
    .pick_stall (pick_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
